// ===== hw/rtl/onewire_rom_search_step_macros.svh =====
// Assertion helpers for the search-ROM step block
`ifndef ONEWIRE_ROM_SEARCH_STEP_MACROS_SVH
`define ONEWIRE_ROM_SEARCH_STEP_MACROS_SVH

// Checked on every rising clock edge, skipped while reset is high
`define ONWS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition in one cycle, property in the next
`define ONWS_NEXT(label, cond, prop, msg) \
   `ONWS_ASSERT(label, (cond) |=> (prop), msg)

// Condition and property in the same cycle
`define ONWS_SAME(label, cond, prop, msg) \
   `ONWS_ASSERT(label, (cond) |-> (prop), msg)

`endif

// ===== hw/rtl/onws_pkg.sv =====
package onws_pkg;

   localparam int unsigned POS_W = 7;
   localparam logic [POS_W-1:0] INITIAL_FORK = 7'd65;

   // request opcodes; the fourth code is unused and ignored
   localparam logic [1:0] OP_CLEAR    = 2'd0;
   localparam logic [1:0] OP_START    = 2'd1;
   localparam logic [1:0] OP_BIT_PAIR = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEARED     = 3'd0,
      ST_STARTED     = 3'd1,
      ST_ACCEPTED    = 3'd2,
      ST_COMPLETE    = 3'd3,
      ST_EXHAUSTED   = 3'd4,
      ST_NO_PRESENCE = 3'd5,
      ST_BUS_ERROR   = 3'd6,
      ST_IGNORED     = 3'd7
   } status_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic       presence;
      logic       id_bit;
      logic       complement_bit;
   } req_item_type;

   typedef struct packed {
      status_type  status;
      logic        direction_bit;
      logic [63:0] rom_address;
      logic [7:0]  device_count;
   } rsp_item_type;

   // search control state, everything but the stored address
   typedef struct packed {
      logic [POS_W-1:0] last_fork;
      logic [POS_W-1:0] new_fork;
      logic [POS_W-1:0] bit_position;
      logic [7:0]       working_byte;
      logic             pass_active;
      logic [7:0]       found_count;
   } ctl_state_type;

   localparam ctl_state_type CTL_RESET = '{
      last_fork:    INITIAL_FORK,
      new_fork:     '0,
      bit_position: 7'd1,
      working_byte: '0,
      pass_active:  1'b0,
      found_count:  '0
   };

endpackage

// ===== hw/rtl/onws_decide.sv =====
module onws_decide import onws_pkg::*; #(
   parameter int unsigned ADDRESS_BITS = 64
) (
   input  req_item_type             item,
   input  ctl_state_type            ctl,
   input  logic [ADDRESS_BITS-1:0]  addr,
   output ctl_state_type            ctl_in,
   output logic [ADDRESS_BITS-1:0]  addr_in,
   output rsp_item_type             rsp
);

   localparam logic [POS_W-1:0] LastPos = POS_W'(ADDRESS_BITS);

   logic [63:0]      addr_wide;
   logic [63:0]      addr_wide_in;
   logic [POS_W-1:0] pos_m1;
   logic [2:0]       bit_in_byte;
   logic [2:0]       byte_idx;
   logic             prev_bit;
   logic             conflict;
   logic             dir;
   logic             byte_done;
   logic             last_bit;
   logic [POS_W-1:0] new_fork_next;
   logic [7:0]       wb_next;
   logic [7:0]       lane_mask;

   always_comb begin
      addr_wide   = 64'(addr);
      pos_m1      = ctl.bit_position - 7'd1;
      bit_in_byte = pos_m1[2:0];
      byte_idx    = pos_m1[5:3];
      prev_bit    = addr_wide[pos_m1[5:0]];
      conflict    = !item.id_bit && !item.complement_bit;

      // at a conflict: follow the old path left of the fork, 1 at it, 0 right of it
      priority if (!conflict) begin
         dir = item.id_bit;
      end else if (ctl.bit_position < ctl.last_fork) begin
         dir = prev_bit;
      end else if (ctl.bit_position == ctl.last_fork) begin
         dir = 1'b1;
      end else begin
         dir = 1'b0;
      end

      if (conflict && !dir) begin
         new_fork_next = ctl.bit_position;
      end else begin
         new_fork_next = ctl.new_fork;
      end

      wb_next   = ctl.working_byte | (8'(dir) << bit_in_byte);
      byte_done = (ctl.bit_position[2:0] == 3'd0);
      last_bit  = (ctl.bit_position >= LastPos);
      // a trailing partial byte only replaces its low bits
      lane_mask = byte_done ? 8'hFF : 8'((9'd1 << ctl.bit_position[2:0]) - 9'd1);
   end

   always_comb begin
      ctl_in           = ctl;
      addr_wide_in     = addr_wide;
      rsp.status       = ST_IGNORED;
      rsp.direction_bit = 1'b0;

      unique case (item.opcode)
         OP_CLEAR: begin
            addr_wide_in       = '0;
            ctl_in.found_count = '0;
            ctl_in.last_fork   = INITIAL_FORK;
            ctl_in.pass_active = 1'b0;
            rsp.status         = ST_CLEARED;
         end
         OP_START: begin
            if (ctl.last_fork == '0) begin
               ctl_in.pass_active = 1'b0;
               rsp.status         = ST_EXHAUSTED;
            end else if (!item.presence) begin
               ctl_in.pass_active = 1'b0;
               rsp.status         = ST_NO_PRESENCE;
            end else begin
               ctl_in.pass_active  = 1'b1;
               ctl_in.bit_position = 7'd1;
               ctl_in.new_fork     = '0;
               ctl_in.working_byte = '0;
               rsp.status          = ST_STARTED;
            end
         end
         OP_BIT_PAIR: begin
            if (ctl.pass_active) begin
               if (item.id_bit && item.complement_bit) begin
                  ctl_in.pass_active = 1'b0;
                  rsp.status         = ST_BUS_ERROR;
               end else begin
                  rsp.direction_bit   = dir;
                  ctl_in.new_fork     = new_fork_next;
                  ctl_in.working_byte = wb_next;
                  if (byte_done || last_bit) begin
                     for (int i = 0; i < 8; i++) begin
                        if (byte_idx == 3'(i)) begin
                           addr_wide_in[i*8 +: 8] = (addr_wide[i*8 +: 8] & ~lane_mask)
                                                  | (wb_next & lane_mask);
                        end
                     end
                  end
                  if (byte_done) begin
                     ctl_in.working_byte = '0;
                  end
                  if (last_bit) begin
                     ctl_in.working_byte = '0;
                     ctl_in.found_count  = ctl.found_count + 8'd1;
                     ctl_in.last_fork    = new_fork_next;
                     ctl_in.pass_active  = 1'b0;
                     rsp.status          = ST_COMPLETE;
                  end else begin
                     ctl_in.bit_position = ctl.bit_position + 7'd1;
                     rsp.status          = ST_ACCEPTED;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      addr_in          = addr_wide_in[ADDRESS_BITS-1:0];
      rsp.rom_address  = addr_wide_in;
      rsp.device_count = ctl_in.found_count;
   end

endmodule

// ===== hw/rtl/onewire_rom_search_step.sv =====
// Decision core of the 1-Wire search-ROM enumeration. Each request item is a clear,
// a start of pass after a bus reset, or one received id/complement bit pair; each
// produces exactly one response item with a status, the direction bit to write back,
// the stored address and the device count. An item is decided in the cycle it is
// accepted and its response appears from the output register on the next cycle, so
// the block takes one item per clock; the only stall comes from that output register
// being full while the response side stalls. ADDRESS_BITS (8..64) sets the address
// length; unused upper bits of rom_address read as zero.
module onewire_rom_search_step import onws_pkg::*; #(
   parameter int unsigned ADDRESS_BITS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   ctl_state_type            ctl_ff, ctl_in, ctl_next;
   logic [ADDRESS_BITS-1:0]  addr_ff, addr_in, addr_next;
   rsp_item_type             rsp_item_ff, rsp_item_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     accept;

   onws_decide #(
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_decide (
      .item    (req_item),
      .ctl     (ctl_ff),
      .addr    (addr_ff),
      .ctl_in  (ctl_next),
      .addr_in (addr_next),
      .rsp     (rsp_item_in)
   );

   assign req_stall    = rsp_valid_ff && rsp_stall;
   assign accept       = req_valid && !req_stall;
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);
   assign ctl_in       = accept ? ctl_next : ctl_ff;
   assign addr_in      = accept ? addr_next : addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff       <= CTL_RESET;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ctl_ff       <= ctl_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== hw/rtl/onws_checker.sv =====
`include "onewire_rom_search_step_macros.svh"

module onws_checker import onws_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input req_item_type req_item,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_item_type rsp_item
);

   logic req_fire;
   logic rsp_held;
   logic bit_step;
   logic clear_fire;
   logic cleared;

   assign req_fire   = req_valid && !req_stall;
   assign rsp_held   = rsp_valid && rsp_stall;
   assign bit_step   = (rsp_item.status == ST_ACCEPTED) || (rsp_item.status == ST_COMPLETE);
   assign clear_fire = req_fire && (req_item.opcode == OP_CLEAR);
   assign cleared    = (rsp_item.status == ST_CLEARED) && (rsp_item.device_count == 8'd0)
                       && (rsp_item.rom_address == 64'd0);

   `ONWS_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp_item), "stalled item changed")
   `ONWS_NEXT(a_one_rsp, req_fire, rsp_valid, "accepted item gave no response")
   `ONWS_NEXT(a_no_spurious, !req_fire && !rsp_held, !rsp_valid, "response without item")
   `ONWS_SAME(a_dir_idle, rsp_valid && !bit_step, !rsp_item.direction_bit, "stray direction bit")
   `ONWS_NEXT(a_clear, clear_fire, cleared, "clear did not reset search")

endmodule

bind onewire_rom_search_step onws_checker u_checker (.*);

// ===== dv/onewire_rom_search_step_test.sv =====
`timescale 1ns / 100ps

module onewire_rom_search_step_test;
   import onws_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLDOFF_CYCLES = 300;

   // Tracks the search state and the responses still owed by the block.
   class search_scoreboard;
      logic [63:0]  address;
      logic [6:0]   last_fork;
      logic [6:0]   new_fork;
      logic [6:0]   bit_pos;
      logic [7:0]   work_byte;
      logic [7:0]   found;
      bit           active;
      rsp_item_type expected_rsp[$];
      int           errors;

      function new();
         address   = '0;
         last_fork = INITIAL_FORK;
         new_fork  = '0;
         bit_pos   = 7'd1;
         work_byte = '0;
         found     = '0;
         active    = 1'b0;
         errors    = 0;
      endfunction

      function rsp_item_type predict_step(req_item_type it);
         rsp_item_type r;
         int           p;
         logic         prev;
         r.status        = ST_IGNORED;
         r.direction_bit = 1'b0;
         p = bit_pos;
         case (it.opcode)
            OP_CLEAR: begin
               address   = '0;
               found     = '0;
               last_fork = INITIAL_FORK;
               active    = 1'b0;
               r.status  = ST_CLEARED;
            end
            OP_START: begin
               if (last_fork == 0) begin
                  active   = 1'b0;
                  r.status = ST_EXHAUSTED;
               end else if (!it.presence) begin
                  active   = 1'b0;
                  r.status = ST_NO_PRESENCE;
               end else begin
                  active    = 1'b1;
                  bit_pos   = 7'd1;
                  new_fork  = '0;
                  work_byte = '0;
                  r.status  = ST_STARTED;
               end
            end
            OP_BIT_PAIR: begin
               if (active) begin
                  prev = address[p-1];
                  if (it.id_bit && it.complement_bit) begin
                     active   = 1'b0;
                     r.status = ST_BUS_ERROR;
                  end else begin
                     if (!it.id_bit && !it.complement_bit) begin
                        // conflict: follow old path, take 1 at the fork, 0 beyond it
                        if (p < last_fork) begin
                           r.direction_bit = prev;
                           if (!prev) new_fork = p[6:0];
                        end else if (p == last_fork) begin
                           r.direction_bit = 1'b1;
                        end else begin
                           r.direction_bit = 1'b0;
                           new_fork = p[6:0];
                        end
                     end else begin
                        r.direction_bit = it.id_bit;
                     end
                     if (r.direction_bit) work_byte[(p-1)%8] = 1'b1;
                     if ((p % 8) == 0) begin
                        address[8*((p-1)/8) +: 8] = work_byte;
                        work_byte = '0;
                     end
                     if (p >= 64) begin
                        work_byte = '0;
                        found     = found + 8'd1;
                        last_fork = new_fork;
                        active    = 1'b0;
                        r.status  = ST_COMPLETE;
                     end else begin
                        bit_pos  = bit_pos + 7'd1;
                        r.status = ST_ACCEPTED;
                     end
                  end
               end
            end
            default: ;
         endcase
         r.rom_address  = address;
         r.device_count = found;
         expected_rsp.push_back(r);
         return r;
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         end
      endfunction

      function void check_response(rsp_item_type got);
         rsp_item_type want;
         if (expected_rsp.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none actual %h", $time, got);
            return;
         end
         want = expected_rsp.pop_front();
         compare_field("status", 64'(want.status), 64'(got.status));
         compare_field("direction_bit", 64'(want.direction_bit), 64'(got.direction_bit));
         compare_field("rom_address", want.rom_address, got.rom_address);
         compare_field("device_count", 64'(want.device_count), 64'(got.device_count));
      endfunction
   endclass

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   req_item_type req_item  = '0;
   logic         rsp_stall = 1'b0;
   logic         req_stall;
   logic         rsp_valid;
   rsp_item_type rsp_item;

   search_scoreboard board = new();
   rsp_item_type     last_exp;
   int               send_idle_pct  = 0;
   int               recv_stall_pct = 0;
   int               item_total     = 0;
   int               rsp_seen       = 0;
   int               quiet_cycles   = 0;
   bit               holdoff_done   = 1'b0;

   onewire_rom_search_step u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_response(rsp_item);
         rsp_seen++;
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("Simulation FAILED");
               $finish;
            end
         end
      end
   end

   // response side: random stalls plus one long hold-off to back up the block
   initial begin
      @(negedge clock);
      forever begin
         if (!holdoff_done && rsp_seen >= 100) begin
            holdoff_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLDOFF_CYCLES) @(negedge clock);
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         @(negedge clock);
      end
   end

   function void set_idling(int mode);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
         default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_item(input req_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      last_exp = board.predict_step(it);
      item_total++;
      @(negedge clock);
   endtask

   task automatic send_op(input logic [1:0] op, input logic pres, input logic id,
                          input logic comp);
      req_item_type it;
      it.opcode         = op;
      it.presence       = pres;
      it.id_bit         = id;
      it.complement_bit = comp;
      send_item(it);
   endtask

   task automatic send_pair(input logic id, input logic comp);
      send_op(OP_BIT_PAIR, 1'($urandom_range(1)), id, comp);
   endtask

   // Full enumeration of a small simulated bus, with occasional disturbances.
   task automatic enumerate_devices(input int ndev);
      logic [63:0] devs[6];
      bit          sel[6];
      logic [63:0] base;
      int          passes;
      int          noise;
      bit          done;
      logic        id;
      logic        comp;
      base = {$urandom, $urandom};
      for (int d = 0; d < ndev; d++) begin
         if ($urandom_range(3) == 0) devs[d] = {$urandom, $urandom};
         else devs[d] = base ^ ({$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom});
      end
      send_op(OP_CLEAR, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      passes = 0;
      done   = 1'b0;
      while (!done && passes < 3 * ndev + 6) begin
         passes++;
         case ($urandom_range(11))
            0: send_op(OP_UNUSED, 1'($urandom_range(1)), 1'($urandom_range(1)),
                       1'($urandom_range(1)));
            1: send_pair(1'($urandom_range(1)), 1'($urandom_range(1)));
            2: send_op(OP_START, 1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
            default: ;
         endcase
         send_op(OP_START, 1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)));
         if (last_exp.status == ST_EXHAUSTED) begin
            done = 1'b1;
         end else begin
            for (int k = 0; k < ndev; k++) sel[k] = 1'b1;
            for (int p = 0; p < 64; p++) begin
               noise = $urandom_range(299);
               if (noise == 0) begin
                  send_pair(1'b1, 1'b1);
                  break;
               end
               if (noise == 1) begin
                  send_op(OP_CLEAR, 1'b1, 1'b0, 1'b0);
                  break;
               end
               // abandon mid-pass; the next start restarts it
               if (noise == 2) break;
               id   = 1'b1;
               comp = 1'b1;
               for (int k = 0; k < ndev; k++) begin
                  if (sel[k]) begin
                     if (devs[k][p]) comp = 1'b0;
                     else id = 1'b0;
                  end
               end
               send_pair(id, comp);
               for (int k = 0; k < ndev; k++) begin
                  if (sel[k] && devs[k][p] != last_exp.direction_bit) sel[k] = 1'b0;
               end
            end
         end
      end
      if (done) begin
         send_op(OP_START, 1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)));
         send_pair(1'($urandom_range(1)), 1'($urandom_range(1)));
      end
   endtask

   // Passes over an arbitrary bus with a conflict on the last bit; every started pass
   // completes an address, and a start that is refused is followed by a clear.
   task automatic count_wrap_passes(input int npass);
      logic id;
      send_op(OP_CLEAR, 1'b0, 1'b0, 1'b0);
      for (int n = 0; n < npass; n++) begin
         set_idling(n % 4);
         send_op(OP_START, 1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)));
         if (last_exp.status != ST_STARTED) begin
            send_op(OP_CLEAR, 1'b0, 1'b0, 1'b0);
         end else begin
            for (int p = 1; p <= 64; p++) begin
               if (p == 64 || $urandom_range(1)) begin
                  send_pair(1'b0, 1'b0);
               end else begin
                  id = 1'($urandom_range(1));
                  send_pair(id, !id);
               end
            end
         end
      end
   endtask

   initial begin
      int start_total;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_idling(0);

      send_pair(1'b0, 1'b0);                      // no pass yet
      send_op(OP_UNUSED, 1'b1, 1'b1, 1'b1);
      send_op(OP_START, 1'b0, 1'b1, 1'b1);        // no presence pulse
      send_op(OP_START, 1'b1, 1'b0, 1'b0);
      send_pair(1'b1, 1'b0);
      send_pair(1'b0, 1'b1);
      send_pair(1'b0, 1'b0);
      send_op(OP_START, 1'b1, 1'b1, 1'b0);        // restart while active
      repeat (9) send_pair(1'b1, 1'b0);
      send_pair(1'b1, 1'b1);                      // bus error keeps the full byte
      send_pair(1'b0, 1'b1);
      send_op(OP_START, 1'b1, 1'b0, 1'b1);
      send_pair(1'b0, 1'b0);
      send_op(OP_CLEAR, 1'b1, 1'b1, 1'b1);        // clear abandons the pass
      send_pair(1'b1, 1'b0);
      send_op(OP_START, 1'b1, 1'b0, 1'b0);

      for (int mode = 0; mode < 4; mode++) begin
         set_idling(mode);
         start_total = item_total;
         while (item_total - start_total < 150) begin
            if ($urandom_range(4) != 0) begin
               enumerate_devices($urandom_range(1, 4));
            end else begin
               repeat (8) send_item(req_item_type'(5'($urandom_range(31))));
            end
         end
      end

      count_wrap_passes(2);

      req_valid <= 1'b0;
      while (board.expected_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
